// File: rtl/shape_record_parser_defines.svh
// Assertion macros for the shape record parser.
// Used by shape_record_parser.sv; expects clk and rst_n in scope.
`ifndef SHAPE_RECORD_PARSER_DEFINES_SVH
`define SHAPE_RECORD_PARSER_DEFINES_SVH

// Checked only outside reset.
`define SRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SRP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/srp_pkg.sv
// Shared types, codes and tables for the shape record parser.
// No dependencies.
`default_nettype none

package srp_pkg;

    localparam logic [8:0] MAX_VERTICES     = 9'd256;
    localparam logic [8:0] MAX_PRIMITIVES   = 9'd256;
    localparam logic [4:0] MAX_POLY_INDICES = 5'd16;

    // Result queue depth; one item may push two records.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [7:0] {
        PH_HEADER = 8'b0000_0001,
        PH_VERT   = 8'b0000_0010,
        PH_CULL   = 8'b0000_0100,
        PH_PRIM   = 8'b0000_1000,
        PH_PAINT  = 8'b0001_0000,
        PH_PSKIP  = 8'b0010_0000,
        PH_INDEX  = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_PRIM   = 2'd1,
        KIND_INDEX  = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    localparam logic [1:0] PRIM_POLYGON = 2'd3;

    typedef struct packed {
        kind_t              record_kind;
        logic [7:0]         item_number;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic [1:0]         prim_kind;
        logic [7:0]         palette_color;
        logic [3:0]         index_count;
        logic [3:0]         index_slot;
        logic [7:0]         vertex_ref;
        logic               parse_ok;
        logic               final_record;
    } rec_t;

    localparam logic [3:0] INDEX_TABLE [16] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd2, 4'd6, 4'd3, 4'd0, 4'd0
    };

    localparam logic [7:0] PALETTE_ROM [128] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F,
        8'h6C, 8'h74, 8'h0F, 8'h1C, 8'h1D, 8'h0E, 8'h1C, 8'h1F,
        8'h0E, 8'hC8, 8'hC6, 8'hC4, 8'h70, 8'h72, 8'h74, 8'hC2,
        8'hC5, 8'hC8, 8'h92, 8'h25, 8'h23, 8'hB5, 8'h1D, 8'h1F,
        8'h13, 8'h03, 8'h0B, 8'h1B, 8'h00, 8'h04, 8'h04, 8'h0C,
        8'h9C, 8'h9A, 8'h98, 8'h96, 8'h2A, 8'h28, 8'h26, 8'h25,
        8'h1B, 8'h1A, 8'h19, 8'h18, 8'h48, 8'h46, 8'h44, 8'h42,
        8'h7B, 8'h79, 8'h78, 8'h75, 8'h5C, 8'h5A, 8'h58, 8'h57,
        8'hAD, 8'hAB, 8'hA9, 8'hA7, 8'h14, 8'h13, 8'h12, 8'h11,
        8'h4D, 8'h4C, 8'h4A, 8'h49, 8'h2D, 8'h2C, 8'h2A, 8'h29,
        8'h9F, 8'hAF, 8'hAE, 8'hAC, 8'h1D, 8'h1C, 8'h12, 8'h5A,
        8'h0F, 8'h07, 8'hC8, 8'hDB, 8'h88, 8'h63, 8'h65, 8'h67,
        8'h68, 8'h6A, 8'h11, 8'h14, 8'h3C, 8'h4D, 8'h2E, 8'h3D,
        8'h2D, 8'hCA, 8'hBE, 8'hBA, 8'hB7, 8'hB4, 8'h00, 8'h1C,
        8'h1E, 8'h10, 8'h14, 8'h44, 8'h36, 8'h27, 8'h2B, 8'h0C
    };

endpackage

`default_nettype wire

// File: rtl/srp_if.sv
// Valid/ready channel interfaces: resource bytes in, parsed records out.
// Depends on srp_pkg.
`default_nettype none

interface srp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface srp_record_if;
    logic               valid;
    logic               ready;
    srp_pkg::kind_t     record_kind;
    logic [7:0]         item_number;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [1:0]         prim_kind;
    logic [7:0]         palette_color;
    logic [3:0]         index_count;
    logic [3:0]         index_slot;
    logic [7:0]         vertex_ref;
    logic               parse_ok;
    logic               final_record;

    modport source (
        output valid, output record_kind, output item_number,
        output coord_x, output coord_y, output coord_z,
        output prim_kind, output palette_color, output index_count,
        output index_slot, output vertex_ref, output parse_ok, output final_record,
        input ready
    );
    modport sink (
        input valid, input record_kind, input item_number,
        input coord_x, input coord_y, input coord_z,
        input prim_kind, input palette_color, input index_count,
        input index_slot, input vertex_ref, input parse_ok, input final_record,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/shape_record_parser.sv
// Shape resource parser: byte stream in, vertex/primitive/index/end records out.
// Depends on srp_pkg, srp_if.sv and shape_record_parser_defines.svh.
//
//   channel   dir  payload                               handshake
//   stream    in   data_byte[7:0], last_byte             valid/ready
//   records   out  record_kind .. final_record (rec_t)   valid/ready
//
// One byte per cycle: each accepted byte updates the parser state and pushes
// zero, one or two records into a 4-entry result queue in the same cycle.
// stream.ready is high while the queue has room for two records, so a byte
// is taken every cycle as long as records drain at one per cycle.
// Records leave the queue one per cycle; a stall on records backs up the
// queue until stream.ready drops. Reset (async, active low) empties the
// queue and restarts the parse at the header.
`default_nettype none
`include "shape_record_parser_defines.svh"

module shape_record_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    srp_byte_if.sink           stream,
    srp_record_if.source       records
);

    // parser state
    srp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  fpos_reg, fpos_next;
    logic [7:0]  vertex_total_reg, vertex_total_next;
    logic [7:0]  prim_total_reg, prim_total_next;
    logic [7:0]  paint_total_reg, paint_total_next;
    logic [39:0] assembly_reg, assembly_next;
    logic [7:0]  vertex_cnt_reg, vertex_cnt_next;
    logic [7:0]  prim_cnt_reg, prim_cnt_next;
    logic [10:0] skip_reg, skip_next;
    logic [7:0]  cur_type_reg, cur_type_next;
    logic [3:0]  slot_reg, slot_next;

    // result queue
    srp_pkg::rec_t                  fifo_reg [srp_pkg::FIFO_DEPTH];
    logic [srp_pkg::FIFO_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [srp_pkg::FIFO_CW-1:0]    count_reg;

    logic        accept, pop;
    logic [7:0]  b;
    logic        last;
    logic [8:0]  vlim, plim, pc_inc, vc_inc;
    logic [4:0]  ilim;
    logic [10:0] skip_dec;
    logic [3:0]  slot_inc;
    logic [7:0]  paint_raw;
    srp_pkg::rec_t hdr_rec, res0, res1;
    logic        res0_vld, res1_vld;

    assign accept = stream.valid && stream.ready;
    assign pop    = records.valid && records.ready;
    assign b      = stream.data_byte;
    assign last   = stream.last_byte;

    assign stream.ready = (count_reg <= srp_pkg::FIFO_CW'(srp_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        logic [4:0] tab;
        vlim = ({1'b0, vertex_total_reg} < srp_pkg::MAX_VERTICES) ?
               {1'b0, vertex_total_reg} : srp_pkg::MAX_VERTICES;
        plim = ({1'b0, prim_total_reg} < srp_pkg::MAX_PRIMITIVES) ?
               {1'b0, prim_total_reg} : srp_pkg::MAX_PRIMITIVES;
        tab  = (cur_type_reg < 8'd16) ? {1'b0, srp_pkg::INDEX_TABLE[cur_type_reg[3:0]]} : 5'd0;
        ilim = (tab < srp_pkg::MAX_POLY_INDICES) ? tab : srp_pkg::MAX_POLY_INDICES;
    end

    assign pc_inc   = {1'b0, prim_cnt_reg} + 9'd1;
    assign vc_inc   = {1'b0, vertex_cnt_reg} + 9'd1;
    assign skip_dec = (skip_reg != 11'd0) ? skip_reg - 11'd1 : skip_reg;
    assign slot_inc = slot_reg + 4'd1;
    // the header only carries a real paint byte when it is built in the paint phase
    assign paint_raw = (phase_reg == srp_pkg::PH_PAINT) ? b : 8'd0;

    always_comb
    begin
        hdr_rec             = '0;
        hdr_rec.record_kind = srp_pkg::KIND_PRIM;
        hdr_rec.item_number = prim_cnt_reg;
        hdr_rec.prim_kind   = (cur_type_reg <= 8'd2) ? cur_type_reg[1:0] : srp_pkg::PRIM_POLYGON;
        hdr_rec.palette_color = paint_raw[7] ? paint_raw : srp_pkg::PALETTE_ROM[paint_raw[6:0]];
        hdr_rec.index_count = (cur_type_reg < 8'd16) ?
                              srp_pkg::INDEX_TABLE[cur_type_reg[3:0]] : 4'd0;
    end

    always_comb
    begin
        phase_next        = phase_reg;
        fpos_next         = fpos_reg;
        vertex_total_next = vertex_total_reg;
        prim_total_next   = prim_total_reg;
        paint_total_next  = paint_total_reg;
        assembly_next     = assembly_reg;
        vertex_cnt_next   = vertex_cnt_reg;
        prim_cnt_next     = prim_cnt_reg;
        skip_next         = skip_reg;
        cur_type_next     = cur_type_reg;
        slot_next         = slot_reg;
        res0     = '0;
        res1     = '0;
        res0_vld = 1'b0;
        res1_vld = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                srp_pkg::PH_HEADER:
                begin
                    case (fpos_reg)
                        3'd0:    vertex_total_next = b;
                        3'd1:    prim_total_next   = b;
                        3'd2:    paint_total_next  = b;
                        default: ;
                    endcase
                    if (fpos_reg >= 3'd3)
                    begin
                        vertex_cnt_next = 8'd0;
                        fpos_next       = 3'd0;
                        if (vlim != 9'd0)
                        begin
                            phase_next = srp_pkg::PH_VERT;
                        end
                        else
                        begin
                            skip_next     = {prim_total_reg, 3'b000};
                            prim_cnt_next = 8'd0;
                            if (prim_total_reg != 8'd0)
                                phase_next = srp_pkg::PH_CULL;
                            else
                                phase_next = (plim == 9'd0) ? srp_pkg::PH_DONE : srp_pkg::PH_PRIM;
                        end
                    end
                    else
                    begin
                        fpos_next = fpos_reg + 3'd1;
                    end
                end
                srp_pkg::PH_VERT:
                begin
                    if (fpos_reg < 3'd5)
                    begin
                        case (fpos_reg)
                            3'd0:    assembly_next[7:0]   = b;
                            3'd1:    assembly_next[15:8]  = b;
                            3'd2:    assembly_next[23:16] = b;
                            3'd3:    assembly_next[31:24] = b;
                            default: assembly_next[39:32] = b;
                        endcase
                        fpos_next = fpos_reg + 3'd1;
                    end
                    else
                    begin
                        res0_vld         = 1'b1;
                        res0.record_kind = srp_pkg::KIND_VERTEX;
                        res0.item_number = vertex_cnt_reg;
                        res0.coord_x     = assembly_reg[15:0];
                        res0.coord_y     = assembly_reg[31:16];
                        res0.coord_z     = {b, assembly_reg[39:32]};
                        assembly_next    = '0;
                        fpos_next        = 3'd0;
                        vertex_cnt_next  = vc_inc[7:0];
                        if (vc_inc >= vlim)
                        begin
                            skip_next     = {prim_total_reg, 3'b000};
                            prim_cnt_next = 8'd0;
                            if (prim_total_reg != 8'd0)
                                phase_next = srp_pkg::PH_CULL;
                            else
                                phase_next = (plim == 9'd0) ? srp_pkg::PH_DONE : srp_pkg::PH_PRIM;
                        end
                    end
                end
                srp_pkg::PH_CULL:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 11'd0)
                    begin
                        fpos_next  = 3'd0;
                        phase_next = ({1'b0, prim_cnt_reg} >= plim) ?
                                     srp_pkg::PH_DONE : srp_pkg::PH_PRIM;
                    end
                end
                srp_pkg::PH_PRIM:
                begin
                    if (fpos_reg == 3'd0)
                    begin
                        cur_type_next = b;
                        fpos_next     = 3'd1;
                    end
                    else
                    begin
                        fpos_next = 3'd0;
                        if (paint_total_reg != 8'd0)
                        begin
                            phase_next = srp_pkg::PH_PAINT;
                            // resource ends before any paint byte
                            if (last)
                            begin
                                res0_vld = 1'b1;
                                res0     = hdr_rec;
                            end
                        end
                        else
                        begin
                            res0_vld  = 1'b1;
                            res0      = hdr_rec;
                            slot_next = 4'd0;
                            if (ilim != 5'd0)
                            begin
                                phase_next = srp_pkg::PH_INDEX;
                            end
                            else
                            begin
                                prim_cnt_next = pc_inc[7:0];
                                phase_next    = (pc_inc >= plim) ? srp_pkg::PH_DONE : srp_pkg::PH_PRIM;
                            end
                        end
                    end
                end
                srp_pkg::PH_PAINT:
                begin
                    res0_vld = 1'b1;
                    res0     = hdr_rec;
                    if (paint_total_reg > 8'd1)
                    begin
                        skip_next  = {3'b000, paint_total_reg - 8'd1};
                        phase_next = srp_pkg::PH_PSKIP;
                    end
                    else
                    begin
                        slot_next = 4'd0;
                        if (ilim != 5'd0)
                        begin
                            phase_next = srp_pkg::PH_INDEX;
                        end
                        else
                        begin
                            prim_cnt_next = pc_inc[7:0];
                            fpos_next     = 3'd0;
                            phase_next    = (pc_inc >= plim) ? srp_pkg::PH_DONE : srp_pkg::PH_PRIM;
                        end
                    end
                end
                srp_pkg::PH_PSKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 11'd0)
                    begin
                        slot_next = 4'd0;
                        if (ilim != 5'd0)
                        begin
                            phase_next = srp_pkg::PH_INDEX;
                        end
                        else
                        begin
                            prim_cnt_next = pc_inc[7:0];
                            fpos_next     = 3'd0;
                            phase_next    = (pc_inc >= plim) ? srp_pkg::PH_DONE : srp_pkg::PH_PRIM;
                        end
                    end
                end
                srp_pkg::PH_INDEX:
                begin
                    res0_vld         = 1'b1;
                    res0.record_kind = srp_pkg::KIND_INDEX;
                    res0.item_number = prim_cnt_reg;
                    res0.index_slot  = slot_reg;
                    res0.vertex_ref  = b;
                    slot_next        = slot_inc;
                    if ({1'b0, slot_inc} >= ilim)
                    begin
                        prim_cnt_next = pc_inc[7:0];
                        fpos_next     = 3'd0;
                        phase_next    = (pc_inc >= plim) ? srp_pkg::PH_DONE : srp_pkg::PH_PRIM;
                    end
                end
                default: ;  // trailing bytes after the last primitive
            endcase

            if (last)
            begin
                res1_vld          = 1'b1;
                res1.record_kind  = srp_pkg::KIND_END;
                res1.parse_ok     = !((phase_reg == srp_pkg::PH_HEADER) && (fpos_reg < 3'd3));
                res1.final_record = 1'b1;
                phase_next        = srp_pkg::PH_HEADER;
                fpos_next         = 3'd0;
                vertex_total_next = 8'd0;
                prim_total_next   = 8'd0;
                paint_total_next  = 8'd0;
                assembly_next     = '0;
                vertex_cnt_next   = 8'd0;
                prim_cnt_next     = 8'd0;
                skip_next         = 11'd0;
                cur_type_next     = 8'd0;
                slot_next         = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= srp_pkg::PH_HEADER;
            fpos_reg         <= 3'd0;
            vertex_total_reg <= 8'd0;
            prim_total_reg   <= 8'd0;
            paint_total_reg  <= 8'd0;
            assembly_reg     <= '0;
            vertex_cnt_reg   <= 8'd0;
            prim_cnt_reg     <= 8'd0;
            skip_reg         <= 11'd0;
            cur_type_reg     <= 8'd0;
            slot_reg         <= 4'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            fpos_reg         <= fpos_next;
            vertex_total_reg <= vertex_total_next;
            prim_total_reg   <= prim_total_next;
            paint_total_reg  <= paint_total_next;
            assembly_reg     <= assembly_next;
            vertex_cnt_reg   <= vertex_cnt_next;
            prim_cnt_reg     <= prim_cnt_next;
            skip_reg         <= skip_next;
            cur_type_reg     <= cur_type_next;
            slot_reg         <= slot_next;
        end
    end

    // result queue: up to two pushes and one pop per cycle
    logic [1:0]                  n_push;
    srp_pkg::rec_t               push0;
    logic [srp_pkg::FIFO_AW-1:0] wr_ptr_p1;

    assign n_push    = {1'b0, res0_vld} + {1'b0, res1_vld};
    assign push0     = res0_vld ? res0 : res1;
    assign wr_ptr_p1 = wr_ptr_reg + srp_pkg::FIFO_AW'(1);

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            fifo_reg[wr_ptr_reg] <= push0;
        if (n_push == 2'd2)
            fifo_reg[wr_ptr_p1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + srp_pkg::FIFO_AW'(n_push);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + srp_pkg::FIFO_AW'(1);
            count_reg <= count_reg + srp_pkg::FIFO_CW'(n_push) - srp_pkg::FIFO_CW'(pop);
        end
    end

    srp_pkg::rec_t head;
    assign head = fifo_reg[rd_ptr_reg];

    assign records.valid         = (count_reg != '0);
    assign records.record_kind   = head.record_kind;
    assign records.item_number   = head.item_number;
    assign records.coord_x       = head.coord_x;
    assign records.coord_y       = head.coord_y;
    assign records.coord_z       = head.coord_z;
    assign records.prim_kind     = head.prim_kind;
    assign records.palette_color = head.palette_color;
    assign records.index_count   = head.index_count;
    assign records.index_slot    = head.index_slot;
    assign records.vertex_ref    = head.vertex_ref;
    assign records.parse_ok      = head.parse_ok;
    assign records.final_record  = head.final_record;

    `SRP_ASSERT_ALWAYS(a_queue_bound, !rst_n || (count_reg <= srp_pkg::FIFO_CW'(srp_pkg::FIFO_DEPTH)), "result queue overflow")
    `SRP_ASSERT(a_last_restarts, (accept && last) |=> (phase_reg == srp_pkg::PH_HEADER && fpos_reg == 3'd0), "parse not restarted after last byte")
    `SRP_ASSERT(a_slot_in_range, (phase_reg == srp_pkg::PH_INDEX) |-> ({1'b0, slot_reg} < ilim), "index slot past type count")
    `SRP_ASSERT(a_final_is_end, records.valid |-> (records.final_record == (records.record_kind == srp_pkg::KIND_END)), "final flag on non-end record")

endmodule

`default_nettype wire
